@@ hdl/blm_pkg.sv @@
// Shared types and constants for the battery level monitor.
package blm_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_DIVIDER_GAIN   = 3'd0;
  localparam logic [2:0] CFG_CELLS          = 3'd1;
  localparam logic [2:0] CFG_CHEMISTRY      = 3'd2;
  localparam logic [2:0] CFG_LOW_LEVEL      = 3'd3;
  localparam logic [2:0] CFG_BLINK_TICKS    = 3'd4;
  localparam logic [2:0] CFG_ON_TIME_TICKS  = 3'd5;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Field widths
  localparam int MV_W      = 12;
  localparam int GAIN_W    = 12;
  localparam int CELLS_W   = 5;
  localparam int LEVEL_W   = 7;
  localparam int BLINK_W   = 16;
  localparam int ON_W      = 32;
  localparam int SUM_W     = 16;
  localparam int COUNT_W   = 4;

  // Level computation widths
  localparam int PROD_W    = SUM_W + GAIN_W;   // sum times gain
  localparam int DIVISOR_W = 17;               // 256 * samples * cells, at most 126976
  localparam int CELL_W    = 20;               // quotient fits, divisor is at least 256
  localparam int ITER_W    = $clog2(PROD_W);

  // Chemistry windows in mV
  localparam logic [CELL_W-1:0] ALK_LO_MV  = 20'd900;
  localparam logic [CELL_W-1:0] ALK_SPAN   = 20'd600;
  localparam logic [CELL_W-1:0] NIMH_LO_MV = 20'd1000;
  localparam logic [CELL_W-1:0] NIMH_SPAN  = 20'd200;
  localparam logic [7:0]        RECIP3     = 8'd171;  // 171/512 ~ 1/3, exact below 512
  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 7'd100;

  // Reset values
  localparam logic [GAIN_W-1:0]  GAIN_RESET    = 12'd512;
  localparam logic [CELLS_W-1:0] CELLS_RESET   = 5'd4;
  localparam logic [LEVEL_W-1:0] LOW_RESET     = 7'd20;
  localparam logic [BLINK_W-1:0] BLINK_RESET   = 16'd500;
  localparam logic [ON_W-1:0]    ON_TIME_RESET = 32'd600000;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_SCALE = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  typedef struct packed {
    logic accept;    // take the input transaction, update counters
    logic load_div;  // form product and divisor, clear the sum
    logic div_step;  // one restoring divide step
    logic scale;     // map the cell voltage onto percent
    logic emit;      // load the output register
  } cmd_t;

  typedef struct packed {
    logic avg_due;   // accepted sample completes an average
    logic div_last;  // last divide step
    logic out_free;  // output register can take a result
  } status_t;

endpackage

@@ hdl/blm_ctrl.sv @@
// Controller state machine sequencing the monitor's datapath.
module blm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  blm_pkg::status_t    status,
  output blm_pkg::cmd_t       cmd
);

  blm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= blm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      blm_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = status.avg_due ? blm_pkg::ST_MUL : blm_pkg::ST_EMIT;
        end
      end
      blm_pkg::ST_MUL: begin
        cmd.load_div = 1'b1;
        state_next   = blm_pkg::ST_DIV;
      end
      blm_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = blm_pkg::ST_SCALE;
        end
      end
      blm_pkg::ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = blm_pkg::ST_EMIT;
      end
      blm_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = blm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = blm_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state != blm_pkg::ST_IDLE);

endmodule

@@ hdl/blm_datapath.sv @@
// Datapath: configuration, counters, level divider and output register.
module blm_datapath #(
  parameter int SAMPLES_PER_AVERAGE = 10,
  parameter int SAMPLE_CEILING_MV   = 3500
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [blm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [blm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            mode,
  input  logic [blm_pkg::MV_W-1:0]        sample_mv,
  input  blm_pkg::cmd_t                   cmd,
  output blm_pkg::status_t                status,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic                            led_on,
  output logic                            battery_low,
  output logic                            power_enable,
  output logic [blm_pkg::LEVEL_W-1:0]     level_percent
);

  // Configuration
  logic [blm_pkg::GAIN_W-1:0]  divider_gain;
  logic [blm_pkg::CELLS_W-1:0] cells_in_series;
  logic                        chemistry;
  logic [blm_pkg::LEVEL_W-1:0] low_level_percent;
  logic [blm_pkg::BLINK_W-1:0] blink_ticks;
  logic [blm_pkg::ON_W-1:0]    on_time_ticks;

  // Monitor state
  logic [blm_pkg::SUM_W-1:0]   sample_sum;
  logic [blm_pkg::COUNT_W-1:0] valid_count;
  logic [blm_pkg::LEVEL_W-1:0] last_level;
  logic                        low_flag;
  logic                        led_level;
  logic [blm_pkg::BLINK_W-1:0] blink_count;
  logic [blm_pkg::ON_W-1:0]    on_count;
  logic                        power_hold;

  // Divider
  logic [blm_pkg::PROD_W-1:0]    quo;
  logic [blm_pkg::DIVISOR_W-1:0] rem;
  logic [blm_pkg::DIVISOR_W-1:0] divisor;
  logic [blm_pkg::ITER_W-1:0]    iter;

  // Input decode
  logic                          sample_ok;
  logic [blm_pkg::SUM_W-1:0]     sum_next;
  logic [blm_pkg::COUNT_W:0]     count_inc;
  logic [blm_pkg::ON_W:0]        on_inc;
  logic [blm_pkg::BLINK_W:0]     blink_inc;
  logic                          blink_fire;

  assign sample_ok  = (sample_mv < blm_pkg::MV_W'(SAMPLE_CEILING_MV));
  assign sum_next   = sample_sum + blm_pkg::SUM_W'(sample_mv);
  assign count_inc  = {1'b0, valid_count} + 1'b1;
  assign on_inc     = {1'b0, on_count} + 1'b1;
  assign blink_inc  = {1'b0, blink_count} + 1'b1;
  assign blink_fire = (blink_inc >= {1'b0, blink_ticks});

  assign status.avg_due  = mode && sample_ok &&
                           (count_inc >= (blm_pkg::COUNT_W + 1)'(SAMPLES_PER_AVERAGE));
  assign status.div_last = (iter == blm_pkg::ITER_W'(blm_pkg::PROD_W - 1));
  assign status.out_free = !out_valid || !out_stall;

  // Divisor: 256 * samples per average * effective cell count
  logic [blm_pkg::CELLS_W-1:0] cells_eff;
  logic [9:0]                  cells_scaled;
  assign cells_eff    = (cells_in_series == '0) ? blm_pkg::CELLS_W'(1) : cells_in_series;
  assign cells_scaled = 10'(cells_eff) * 10'(SAMPLES_PER_AVERAGE);

  // Restoring divide step
  logic [blm_pkg::DIVISOR_W:0] rem_shift;
  logic                        rem_ge;
  assign rem_shift = {rem, quo[blm_pkg::PROD_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, divisor});

  // Percent mapping
  logic [blm_pkg::CELL_W-1:0]  cell_mv;
  logic [blm_pkg::CELL_W-1:0]  win_lo;
  logic [blm_pkg::CELL_W-1:0]  win_span;
  logic [blm_pkg::CELL_W-1:0]  delta;
  logic [16:0]                 third_prod;
  logic [blm_pkg::LEVEL_W-1:0] level_calc;

  assign cell_mv    = quo[blm_pkg::CELL_W-1:0];
  assign win_lo     = chemistry ? blm_pkg::NIMH_LO_MV : blm_pkg::ALK_LO_MV;
  assign win_span   = chemistry ? blm_pkg::NIMH_SPAN : blm_pkg::ALK_SPAN;
  assign delta      = cell_mv - win_lo;
  assign third_prod = 17'(delta[9:1]) * 17'(blm_pkg::RECIP3);

  always_comb begin
    if (cell_mv <= win_lo) begin
      level_calc = '0;
    end else if (delta >= win_span) begin
      level_calc = blm_pkg::FULL_LEVEL;
    end else if (chemistry) begin
      level_calc = delta[7:1];
    end else begin
      level_calc = third_prod[15:9];
    end
  end

  // Configuration and monitor state
  always_ff @(posedge clk) begin
    if (rst) begin
      divider_gain      <= blm_pkg::GAIN_RESET;
      cells_in_series   <= blm_pkg::CELLS_RESET;
      chemistry         <= 1'b0;
      low_level_percent <= blm_pkg::LOW_RESET;
      blink_ticks       <= blm_pkg::BLINK_RESET;
      on_time_ticks     <= blm_pkg::ON_TIME_RESET;
      sample_sum        <= '0;
      valid_count       <= '0;
      last_level        <= blm_pkg::FULL_LEVEL;
      low_flag          <= 1'b0;
      led_level         <= 1'b1;
      blink_count       <= '0;
      on_count          <= '0;
      power_hold        <= 1'b1;
      iter              <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          blm_pkg::CFG_DIVIDER_GAIN:  divider_gain      <= cfg_data[blm_pkg::GAIN_W-1:0];
          blm_pkg::CFG_CELLS:         cells_in_series   <= cfg_data[blm_pkg::CELLS_W-1:0];
          blm_pkg::CFG_CHEMISTRY:     chemistry         <= cfg_data[0];
          blm_pkg::CFG_LOW_LEVEL:     low_level_percent <= cfg_data[blm_pkg::LEVEL_W-1:0];
          blm_pkg::CFG_BLINK_TICKS:   blink_ticks       <= cfg_data[blm_pkg::BLINK_W-1:0];
          blm_pkg::CFG_ON_TIME_TICKS: on_time_ticks     <= cfg_data[blm_pkg::ON_W-1:0];
          default: begin
          end
        endcase
      end

      if (cmd.accept) begin
        if (mode) begin
          if (sample_ok) begin
            sample_sum <= sum_next;
            if (status.avg_due) begin
              valid_count <= '0;
            end else begin
              valid_count <= count_inc[blm_pkg::COUNT_W-1:0];
            end
          end
        end else begin
          if (power_hold) begin
            on_count <= on_inc[blm_pkg::ON_W-1:0];
            if (on_inc >= {1'b0, on_time_ticks}) begin
              power_hold <= 1'b0;
            end
          end
          if (blink_fire) begin
            blink_count <= '0;
            if (last_level < low_level_percent) begin
              low_flag  <= 1'b1;
              led_level <= !led_level;
            end else begin
              low_flag  <= 1'b0;
              led_level <= 1'b0;
            end
          end else begin
            blink_count <= blink_inc[blm_pkg::BLINK_W-1:0];
          end
        end
      end

      if (cmd.load_div) begin
        sample_sum <= '0;
        iter       <= '0;
      end
      if (cmd.div_step) begin
        iter <= iter + 1'b1;
      end
      if (cmd.scale) begin
        last_level <= level_calc;
      end
    end
  end

  // Divider operands
  always_ff @(posedge clk) begin
    if (cmd.load_div) begin
      quo     <= blm_pkg::PROD_W'(sample_sum) * blm_pkg::PROD_W'(divider_gain);
      rem     <= '0;
      divisor <= {cells_scaled[8:0], 8'b0};
    end else if (cmd.div_step) begin
      quo <= {quo[blm_pkg::PROD_W-2:0], rem_ge};
      if (rem_ge) begin
        rem <= blm_pkg::DIVISOR_W'(rem_shift - {1'b0, divisor});
      end else begin
        rem <= rem_shift[blm_pkg::DIVISOR_W-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      led_on        <= 1'b1;
      battery_low   <= 1'b0;
      power_enable  <= 1'b1;
      level_percent <= blm_pkg::FULL_LEVEL;
    end else if (cmd.emit) begin
      out_valid     <= 1'b1;
      led_on        <= led_level;
      battery_low   <= low_flag;
      power_enable  <= power_hold;
      level_percent <= last_level;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ hdl/battery_level_monitor_top.sv @@
// Sequence: a tick or a sample that leaves the average open goes from accept to the
// output load; a sample that completes an average passes through the product,
// 28 steps of the restoring divider, scaling and the output load.
// Flow: one transaction at a time; a finished result waits in the output register.
// Reset: synchronous, active high; sets config, counters and outputs to defaults.
// Top level of the battery level monitor.
module battery_level_monitor_top #(
  parameter int SAMPLES_PER_AVERAGE = 10,
  parameter int SAMPLE_CEILING_MV   = 3500
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_wr_en,
  input  logic [blm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [blm_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input channel: ticks and converter samples
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            mode,
  input  logic [blm_pkg::MV_W-1:0]        sample_mv,
  // output channel: one result transaction per input transaction
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            led_on,
  output logic                            battery_low,
  output logic                            power_enable,
  output logic [blm_pkg::LEVEL_W-1:0]     level_percent
);

  // Commands from the sequencer, status back from the datapath
  blm_pkg::cmd_t    cmd;
  blm_pkg::status_t status;

  // Sequence accept, averaging divide and output load.
  // Input is taken only in idle; a finished result waits in the output
  // register, so the next transaction can come in while it is stalled.
  blm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold configuration, tick counters, sample accumulator, divider
  // and the output register.
  blm_datapath #(
    .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
    .SAMPLE_CEILING_MV   (SAMPLE_CEILING_MV)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mode          (mode),
    .sample_mv     (sample_mv),
    .cmd           (cmd),
    .status        (status),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .led_on        (led_on),
    .battery_low   (battery_low),
    .power_enable  (power_enable),
    .level_percent (level_percent)
  );

endmodule

@@ hdl/blm_checker.sv @@
// Port-level checker for the battery level monitor, bound to the top level.
module blm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        power_enable,
  input logic [blm_pkg::LEVEL_W-1:0] level_percent
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // One transaction in flight: stall right after an accept.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction accepted while busy");

  // Level never leaves 0..100.
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> level_percent <= blm_pkg::FULL_LEVEL)
    else $error("level above one hundred");

  // Power, once dropped, stays off until reset.
  a_power_latched: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(power_enable) |-> !power_enable)
    else $error("power enable came back without reset");

endmodule

bind battery_level_monitor_top blm_checker u_blm_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .power_enable  (power_enable),
  .level_percent (level_percent)
);

@@ dv/tb_top.sv @@
// Self-checking testbench for the battery level monitor: directed table, then random phases.
module tb_top;

  // Input transaction kinds on the mode field
  localparam logic MODE_TICK   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // Register index outside the map; a write there must change nothing
  localparam logic [blm_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;

  // Behavior constants of the monitor
  localparam int AVG_SAMPLES = 10;
  localparam int CEILING_MV  = 3500;
  localparam int ALK_MIN_MV  = 900;
  localparam int ALK_MAX_MV  = 1500;
  localparam int NIMH_MIN_MV = 1000;
  localparam int NIMH_MAX_MV = 1200;
  localparam int MAX_LEVEL   = 100;

  // Run shape
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 53;
  localparam int SETTLE_CYCLES = 40;          // extra wait after the last owed reading is back
  localparam int RUN_LIMIT     = 5_000_000;   // several times the slowest correct run

  typedef struct packed {
    logic                        led;
    logic                        low;
    logic                        pwr;
    logic [blm_pkg::LEVEL_W-1:0] level;
  } gauge_out_t;

  typedef enum logic [1:0] {
    ROW_TICK,
    ROW_SAMPLE,
    ROW_REG
  } row_kind_t;

  // One line of the directed table: an input transaction or a register write
  typedef struct packed {
    row_kind_t                       kind;
    logic [blm_pkg::CFG_INDEX_W-1:0] index;   // register for ROW_REG
    logic [blm_pkg::CFG_DATA_W-1:0]  value;   // register data, or millivolts for items
    logic                            typed;   // expectation given in the table itself
    gauge_out_t                      want;
  } plan_row_t;

  logic                            clk;
  logic                            rst;
  logic                            cfg_wr_en;
  logic [blm_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [blm_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  logic                            mode;
  logic [blm_pkg::MV_W-1:0]        sample_mv;
  logic                            out_valid;
  logic                            out_stall;
  logic                            led_on;
  logic                            battery_low;
  logic                            power_enable;
  logic [blm_pkg::LEVEL_W-1:0]     level_percent;

  battery_level_monitor_top uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .sample_mv     (sample_mv),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .led_on        (led_on),
    .battery_low   (battery_low),
    .power_enable  (power_enable),
    .level_percent (level_percent)
  );

  // Shadow copy of the configuration registers
  logic [blm_pkg::GAIN_W-1:0]  gain_cfg;
  logic [blm_pkg::CELLS_W-1:0] cells_cfg;
  logic                        chem_cfg;
  logic [blm_pkg::LEVEL_W-1:0] low_cfg;
  logic [blm_pkg::BLINK_W-1:0] blink_cfg;
  logic [blm_pkg::ON_W-1:0]    on_cfg;

  // Shadow copy of the monitor state
  logic [blm_pkg::SUM_W-1:0]   sum_acc;
  logic [blm_pkg::COUNT_W-1:0] count_acc;
  logic [blm_pkg::LEVEL_W-1:0] level_now;
  logic                        low_now;
  logic                        led_now;
  logic                        hold_now;
  logic [blm_pkg::BLINK_W-1:0] blink_cnt;
  logic [blm_pkg::ON_W-1:0]    uptime_cnt;

  // Gauge readings still owed by the block, oldest first
  gauge_out_t  expected_q[$];
  int unsigned mismatch_count = 0;
  bit          calm = 1'b0;   // when set, neither side idles

  // Clock with a period of 10 time units
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  task automatic reset_gauge();
    gain_cfg   = blm_pkg::GAIN_RESET;
    cells_cfg  = blm_pkg::CELLS_RESET;
    chem_cfg   = 1'b0;
    low_cfg    = blm_pkg::LOW_RESET;
    blink_cfg  = blm_pkg::BLINK_RESET;
    on_cfg     = blm_pkg::ON_TIME_RESET;
    sum_acc    = '0;
    count_acc  = '0;
    level_now  = blm_pkg::LEVEL_W'(MAX_LEVEL);
    low_now    = 1'b0;
    led_now    = 1'b1;
    hold_now   = 1'b1;
    blink_cnt  = '0;
    uptime_cnt = '0;
  endtask

  task automatic apply_cfg(input logic [blm_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [blm_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      blm_pkg::CFG_DIVIDER_GAIN:  gain_cfg  = data[blm_pkg::GAIN_W-1:0];
      blm_pkg::CFG_CELLS:         cells_cfg = data[blm_pkg::CELLS_W-1:0];
      blm_pkg::CFG_CHEMISTRY:     chem_cfg  = data[0];
      blm_pkg::CFG_LOW_LEVEL:     low_cfg   = data[blm_pkg::LEVEL_W-1:0];
      blm_pkg::CFG_BLINK_TICKS:   blink_cfg = data[blm_pkg::BLINK_W-1:0];
      blm_pkg::CFG_ON_TIME_TICKS: on_cfg    = data[blm_pkg::ON_W-1:0];
      default: ;
    endcase
  endtask

  // Map a finished sum of samples onto 0..100 percent of the chemistry window
  function automatic logic [blm_pkg::LEVEL_W-1:0] percent_of_sum(
      input logic [blm_pkg::SUM_W-1:0] sum);
    longint unsigned cells, lo, hi, cellv, pct;
    cells = (cells_cfg == 0) ? 1 : cells_cfg;
    lo    = chem_cfg ? NIMH_MIN_MV : ALK_MIN_MV;
    hi    = chem_cfg ? NIMH_MAX_MV : ALK_MAX_MV;
    cellv = sum;
    cellv = cellv * gain_cfg;
    cellv = cellv / (256 * AVG_SAMPLES);
    cellv = cellv / cells;
    if (cellv <= lo) return '0;
    pct = (cellv - lo) * 100 / (hi - lo);
    if (pct > MAX_LEVEL) return blm_pkg::LEVEL_W'(MAX_LEVEL);
    return pct[blm_pkg::LEVEL_W-1:0];
  endfunction

  // Advance the shadow state by one input transaction and return the gauge reading
  function automatic gauge_out_t gauge_step(input logic m,
                                            input logic [blm_pkg::MV_W-1:0] mv);
    logic [blm_pkg::BLINK_W:0] next_blink;
    gauge_out_t                r;
    if (m == MODE_SAMPLE) begin
      if (mv < CEILING_MV) begin
        sum_acc   = sum_acc + mv;
        count_acc = count_acc + 1'b1;
        if (count_acc >= AVG_SAMPLES) begin
          level_now = percent_of_sum(sum_acc);
          sum_acc   = '0;
          count_acc = '0;
        end
      end
    end else begin
      if (hold_now) begin
        uptime_cnt = uptime_cnt + 1'b1;
        if (uptime_cnt >= on_cfg) hold_now = 1'b0;
      end
      next_blink = blink_cnt + 1'b1;
      if (next_blink >= blink_cfg) begin
        blink_cnt = '0;
        if (level_now < low_cfg) begin
          low_now = 1'b1;
          led_now = ~led_now;
        end else begin
          low_now = 1'b0;
          led_now = 1'b0;
        end
      end else begin
        blink_cnt = next_blink[blm_pkg::BLINK_W-1:0];
      end
    end
    r.led   = led_now;
    r.low   = low_now;
    r.pwr   = hold_now;
    r.level = level_now;
    return r;
  endfunction

  // Pick a sample whose average lands the cell voltage near the chemistry window
  function automatic logic [blm_pkg::MV_W-1:0] aim_sample();
    longint unsigned cells, target, avg;
    cells  = (cells_cfg == 0) ? 1 : cells_cfg;
    target = chem_cfg ? $urandom_range(NIMH_MIN_MV - 30, NIMH_MAX_MV + 30)
                      : $urandom_range(ALK_MIN_MV - 60, ALK_MAX_MV + 60);
    avg = (gain_cfg == 0) ? CEILING_MV - 1 : target * cells * 256 / gain_cfg;
    if (avg > CEILING_MV - 1) avg = CEILING_MV - 1;
    return blm_pkg::MV_W'(avg);
  endfunction

  // Fill register bits above the field with random junk; the block must drop them
  function automatic logic [blm_pkg::CFG_DATA_W-1:0] with_junk(
      input logic [blm_pkg::CFG_DATA_W-1:0] val, input int w);
    logic [blm_pkg::CFG_DATA_W-1:0] mask;
    mask = (32'h1 << w) - 1;
    return ($urandom & ~mask) | (val & mask);
  endfunction

  // Offer one transaction, hold it until taken, then log what the block owes for it
  task automatic send_item(input logic m, input logic [blm_pkg::MV_W-1:0] mv,
                           input logic typed, input gauge_out_t want);
    gauge_out_t  pred;
    int unsigned gap;
    in_valid  <= 1'b1;
    mode      <= m;
    sample_mv <= mv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = gauge_step(m, mv);
    expected_q.push_back(typed ? want : pred);
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every owed reading is back and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [blm_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [blm_pkg::CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_cfg(idx, data);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // One random phase: fresh settings, then a mix of ticks, aimed samples and noise
  task automatic run_phase(input int p);
    logic [blm_pkg::CFG_DATA_W-1:0] gain_v, cells_v, low_v, blink_v, on_v;
    int unsigned                    r;
    case (p)
      0: gain_v = 4095;
      1: gain_v = 1;
      default: gain_v = $urandom_range(200, 4095);
    endcase
    r = $urandom_range(0, 99);
    if (p == 2) cells_v = 16;
    else if (p == 3) cells_v = 1;
    else if (r < 80) cells_v = $urandom_range(1, 16);
    else if (r < 90) cells_v = $urandom_range(17, 31);
    else cells_v = 0;
    case (p)
      4: low_v = 0;
      5: low_v = MAX_LEVEL;
      6: low_v = 127;
      default: low_v = $urandom_range(0, MAX_LEVEL);
    endcase
    case (p)
      6: blink_v = 65535;
      7: blink_v = 1;
      default: blink_v = $urandom_range(0, 12);
    endcase
    // Keep power held until the last phase; there a zero on-time drops it on the first tick
    if (p == PHASES - 1) on_v = 0;
    else if (p == 0) on_v = 32'hFFFF_FFFF;
    else on_v = $urandom | 32'h0100_0000;

    calm = (p == 2) || (p == 5);
    // Hold off until the block is idle before touching its registers
    drain();
    write_reg(blm_pkg::CFG_DIVIDER_GAIN, with_junk(gain_v, blm_pkg::GAIN_W));
    write_reg(blm_pkg::CFG_CELLS, with_junk(cells_v, blm_pkg::CELLS_W));
    write_reg(blm_pkg::CFG_CHEMISTRY, with_junk(p % 2, 1));
    write_reg(blm_pkg::CFG_LOW_LEVEL, with_junk(low_v, blm_pkg::LEVEL_W));
    write_reg(blm_pkg::CFG_BLINK_TICKS, with_junk(blink_v, blm_pkg::BLINK_W));
    write_reg(blm_pkg::CFG_ON_TIME_TICKS, on_v);

    for (int i = 0; i < PHASE_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_item(MODE_TICK, blm_pkg::MV_W'($urandom_range(0, 4095)), 1'b0, '0);
      end else if (r < 85) begin
        send_item(MODE_SAMPLE, aim_sample(), 1'b0, '0);
      end else if (r < 93) begin
        send_item(MODE_SAMPLE, blm_pkg::MV_W'($urandom_range(CEILING_MV, 4095)), 1'b0, '0);
      end else begin
        send_item(MODE_SAMPLE, blm_pkg::MV_W'($urandom_range(0, 4095)), 1'b0, '0);
      end
    end
  endtask

  // Receiver: stall in random bursts, drop the stall entirely in calm phases
  initial begin
    int unsigned hold_left;
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst || calm) begin
        out_stall <= 1'b0;
        hold_left = 0;
      end else if (hold_left != 0) begin
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        hold_left = pick_gap();
      end
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Checker: every result transaction is matched against the oldest owed reading
  always @(posedge clk) begin
    gauge_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing owed: led %0d low %0d power %0d level %0d",
                 $time, led_on, battery_low, power_enable, level_percent);
        mismatch_count++;
      end else begin
        want = expected_q.pop_front();
        compare_field("led_on", want.led, led_on);
        compare_field("battery_low", want.low, battery_low);
        compare_field("power_enable", want.pwr, power_enable);
        compare_field("level_percent", want.level, level_percent);
      end
    end
  end

  // Stimulus: directed table first, then the random phases
  initial begin
    plan_row_t  plan[$];
    plan_row_t  row;
    gauge_out_t at_reset;
    gauge_out_t drained;

    rst       = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    mode      = MODE_TICK;
    sample_mv = '0;
    reset_gauge();

    at_reset = '{1'b1, 1'b0, 1'b1, blm_pkg::LEVEL_W'(MAX_LEVEL)};
    drained  = '{1'b1, 1'b0, 1'b1, blm_pkg::LEVEL_W'(0)};

    // A write outside the register map must leave every setting alone
    plan.push_back('{ROW_REG, CFG_UNUSED, 32'hFFFF_FFFF, 1'b0, '0});
    // First tick after reset, then samples at and above the ceiling are dropped
    plan.push_back('{ROW_TICK, CFG_UNUSED, 32'hFFF, 1'b1, at_reset});
    plan.push_back('{ROW_SAMPLE, CFG_UNUSED, CEILING_MV, 1'b1, at_reset});
    plan.push_back('{ROW_SAMPLE, CFG_UNUSED, 32'hFFF, 1'b1, at_reset});
    // Zero cell count counts as one cell; the full-range average clamps at the top
    plan.push_back('{ROW_REG, blm_pkg::CFG_CELLS, 32'd0, 1'b0, '0});
    for (int k = 0; k < AVG_SAMPLES; k++)
      plan.push_back('{ROW_SAMPLE, CFG_UNUSED, (k % 2) ? CEILING_MV - 1 : 0, 1'b1, at_reset});
    // Zero gain forces the level to zero, whatever the cells and chemistry
    plan.push_back('{ROW_REG, blm_pkg::CFG_DIVIDER_GAIN, 32'd0, 1'b0, '0});
    plan.push_back('{ROW_REG, blm_pkg::CFG_CELLS, 32'd31, 1'b0, '0});
    plan.push_back('{ROW_REG, blm_pkg::CFG_CHEMISTRY, 32'd1, 1'b0, '0});
    for (int k = 0; k < AVG_SAMPLES; k++)
      plan.push_back('{ROW_SAMPLE, CFG_UNUSED, 250 * k + 1000, 1'b1,
                       (k == AVG_SAMPLES - 1) ? drained : at_reset});
    // Threshold above one hundred and a zero blink period: every tick checks and toggles
    plan.push_back('{ROW_REG, blm_pkg::CFG_LOW_LEVEL, 32'd127, 1'b0, '0});
    plan.push_back('{ROW_REG, blm_pkg::CFG_BLINK_TICKS, 32'd0, 1'b0, '0});
    plan.push_back('{ROW_TICK, CFG_UNUSED, 32'd0, 1'b1,
                     '{1'b0, 1'b1, 1'b1, blm_pkg::LEVEL_W'(0)}});
    plan.push_back('{ROW_TICK, CFG_UNUSED, 32'd0, 1'b1,
                     '{1'b1, 1'b1, 1'b1, blm_pkg::LEVEL_W'(0)}});

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      row = plan[i];
      case (row.kind)
        ROW_REG: begin
          drain();
          write_reg(row.index, row.value);
        end
        ROW_TICK: send_item(MODE_TICK, row.value[blm_pkg::MV_W-1:0], row.typed, row.want);
        default: send_item(MODE_SAMPLE, row.value[blm_pkg::MV_W-1:0], row.typed, row.want);
      endcase
    end

    for (int p = 0; p < PHASES; p++) run_phase(p);

    // Let the last readings come back, then give the verdict
    drain();
    if (mismatch_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // Watchdog: a hung handshake ends the run
  initial begin
    #(RUN_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
hdl/blm_pkg.sv
hdl/blm_ctrl.sv
hdl/blm_datapath.sv
hdl/battery_level_monitor_top.sv
hdl/blm_checker.sv
dv/tb_top.sv
